// ===== design/smrb_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Slotted message ring buffer package
// Shared types, codes and default sizes of the slotted message ring buffer.
// ---------------------------------------------------------------------------
package smrb_pkg;

    // Default sizes of the ring.
    localparam int unsigned SLOTS_DEF    = 16;
    localparam int unsigned MAX_ROOM_DEF = 64;

    // Configuration register file.
    localparam int unsigned CFG_DATA_W = 7;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOM_BYTES = 1'b1;
    localparam logic [4:0] SLOT_COUNT_RST = 5'd16;
    localparam logic [6:0] ROOM_BYTES_RST = 7'd64;

    // Operation codes of an input item.
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_EMPTY    = 2'd2,
        STAT_TOO_LONG = 2'd3
    } status_t;

    // Input item.
    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
        logic       end_of_message;
        logic       empty_message;
    } in_item_t;

    // Result item.
    typedef struct packed {
        status_t     result_status;
        logic [7:0]  out_byte;
        logic [6:0]  message_length;
        logic        final_flag;
        logic [31:0] drop_total;
    } out_item_t;

    // Control sequencer states.
    typedef enum logic {
        ST_IDLE,
        ST_POP
    } state_t;

endpackage

// ===== design/slotted_message_ring_buffer.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Slotted message ring buffer
// A ring of fixed-size slots in a byte memory holds variable-length messages,
// with a second memory holding the stored length of each slot.
// ---------------------------------------------------------------------------
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+------------------------
//  s_      | in        | s_valid / s_ready      | s_item (smrb_pkg::in_item_t)
//  m_      | out       | m_valid / m_ready      | m_item (smrb_pkg::out_item_t)
//  cfg_    | in        | cfg_we                 | cfg_index, cfg_data
//
// A push gives one result item.
// A pop of an empty ring gives one empty result. A pop of a message first
// reads the length and byte memories, then gives one byte per cycle while
// the output is not stalled; a zero-length message gives one empty result.
// Reset is synchronous and active low; the memories are not cleared, no
// clearing pass is needed.
// A stalled output holds the block: no item is taken while a result waits
// and m_ready is low.
// ---------------------------------------------------------------------------
module slotted_message_ring_buffer #(
    parameter int unsigned SLOTS    = smrb_pkg::SLOTS_DEF,
    parameter int unsigned MAX_ROOM = smrb_pkg::MAX_ROOM_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input item channel.
    input  logic                             s_valid,
    output logic                             s_ready,
    input  smrb_pkg::in_item_t               s_item,
    // Result item channel.
    output logic                             m_valid,
    input  logic                             m_ready,
    output smrb_pkg::out_item_t              m_item,
    // Configuration write port.
    input  logic                             cfg_we,
    input  logic [smrb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [smrb_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned CNT_W  = $clog2(SLOTS + 1);
    localparam int unsigned OFF_W  = $clog2(MAX_ROOM + 1);
    localparam int unsigned DEPTH  = SLOTS * MAX_ROOM;
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Storage.
    logic [7:0]       store_mem [DEPTH];
    logic [OFF_W-1:0] len_mem   [SLOTS];

    // Configuration registers.
    logic [4:0] slot_count_reg, slot_count_next;
    logic [6:0] room_bytes_reg, room_bytes_next;

    // Ring control state.
    smrb_pkg::state_t    state_reg, state_next;
    logic [SLOT_W-1:0]   ws_reg, ws_next;
    logic [SLOT_W-1:0]   rs_reg, rs_next;
    logic [OFF_W-1:0]    byte_off_reg, byte_off_next;
    logic                ovl_reg, ovl_next;
    logic [31:0]         drop_cnt_reg, drop_cnt_next;
    logic [OFF_W-1:0]    pop_idx_reg, pop_idx_next;
    logic [ADDR_W-1:0]   pop_addr_reg, pop_addr_next;
    logic                m_valid_reg, m_valid_next;
    smrb_pkg::out_item_t m_item_reg, m_item_next;

    // Memory ports.
    logic              st_we, st_re;
    logic [ADDR_W-1:0] st_waddr, st_raddr;
    logic [7:0]        st_rdata_reg;
    logic              len_we, len_re;
    logic [OFF_W-1:0]  len_wdata;
    logic [OFF_W-1:0]  len_rdata_reg;

    // Derived values.
    logic [CNT_W-1:0]  eff_slots;
    logic [OFF_W-1:0]  eff_room;
    logic [CNT_W-1:0]  ws_inc;
    logic [SLOT_W-1:0] ws_wrap;
    logic [CNT_W-1:0]  rs_inc;
    logic [SLOT_W-1:0] rs_wrap;
    logic              out_free;
    logic              s_accept;
    logic              ring_empty;
    logic              ring_full;
    logic              store_byte;
    logic              fits;
    logic              pop_last;
    logic [OFF_W-1:0]  off_new;
    logic [ADDR_W-1:0] ws_base;
    logic [ADDR_W-1:0] rs_base;

    // Clamp the configuration to its usable range.
    always_comb begin
        if (slot_count_reg < 5'd2) begin
            eff_slots = CNT_W'(2);
        end else if (32'(slot_count_reg) > SLOTS) begin
            eff_slots = CNT_W'(SLOTS);
        end else begin
            eff_slots = CNT_W'(slot_count_reg);
        end
        if (room_bytes_reg < 7'd1) begin
            eff_room = OFF_W'(1);
        end else if (32'(room_bytes_reg) > MAX_ROOM) begin
            eff_room = OFF_W'(MAX_ROOM);
        end else begin
            eff_room = OFF_W'(room_bytes_reg);
        end
    end

    // Slot pointer advance with wrap at the configured slot count.
    assign ws_inc  = CNT_W'(ws_reg) + CNT_W'(1);
    assign ws_wrap = (ws_inc >= eff_slots) ? '0 : SLOT_W'(ws_inc);
    assign rs_inc  = CNT_W'(rs_reg) + CNT_W'(1);
    assign rs_wrap = (rs_inc >= eff_slots) ? '0 : SLOT_W'(rs_inc);

    assign ring_empty = (ws_reg == rs_reg);
    assign ring_full  = (ws_wrap == rs_reg);
    assign ws_base    = ADDR_W'(ws_reg) * ADDR_W'(MAX_ROOM);
    assign rs_base    = ADDR_W'(rs_reg) * ADDR_W'(MAX_ROOM);

    // Handshake.
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == smrb_pkg::ST_IDLE) && out_free;
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;

    // Push decode.
    assign store_byte = !(s_item.end_of_message && s_item.empty_message);
    assign fits       = (byte_off_reg < eff_room);
    assign off_new    = (store_byte && fits) ? byte_off_reg + OFF_W'(1) : byte_off_reg;
    assign pop_last   = ((pop_idx_reg + OFF_W'(1)) == len_rdata_reg);

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            smrb_pkg::ST_IDLE: begin
                if (s_accept && s_item.action == smrb_pkg::ACT_POP && !ring_empty) begin
                    state_next = smrb_pkg::ST_POP;
                end
            end
            smrb_pkg::ST_POP: begin
                if (out_free && (len_rdata_reg == '0 || pop_last)) begin
                    state_next = smrb_pkg::ST_IDLE;
                end
            end
            default: state_next = smrb_pkg::ST_IDLE;
        endcase
    end

    // Datapath, memory control and result formation.
    always_comb begin
        slot_count_next = slot_count_reg;
        room_bytes_next = room_bytes_reg;
        ws_next         = ws_reg;
        rs_next         = rs_reg;
        byte_off_next   = byte_off_reg;
        ovl_next        = ovl_reg;
        drop_cnt_next   = drop_cnt_reg;
        pop_idx_next    = pop_idx_reg;
        pop_addr_next   = pop_addr_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_item_next     = m_item_reg;
        st_we           = 1'b0;
        st_waddr        = ws_base + ADDR_W'(byte_off_reg);
        st_re           = 1'b0;
        st_raddr        = pop_addr_reg;
        len_we          = 1'b0;
        len_wdata       = off_new;
        len_re          = 1'b0;

        case (state_reg)
            smrb_pkg::ST_IDLE: begin
                if (s_accept && s_item.action == smrb_pkg::ACT_PUSH) begin
                    // Store the byte if the slot has room; a final item closes the message.
                    m_valid_next                = 1'b1;
                    m_item_next.result_status   = smrb_pkg::STAT_OK;
                    m_item_next.out_byte        = 8'd0;
                    m_item_next.message_length  = 7'(off_new);
                    m_item_next.final_flag      = 1'b1;
                    m_item_next.drop_total      = drop_cnt_reg;
                    st_we                       = store_byte && fits;
                    byte_off_next               = off_new;
                    if (store_byte && !fits) begin
                        m_item_next.result_status = smrb_pkg::STAT_TOO_LONG;
                        ovl_next                  = 1'b1;
                    end
                    if (s_item.end_of_message) begin
                        if (ovl_reg || (store_byte && !fits)) begin
                            m_item_next.result_status = smrb_pkg::STAT_TOO_LONG;
                        end
                        if (ring_full) begin
                            m_item_next.result_status = smrb_pkg::STAT_FULL;
                            if (drop_cnt_reg != '1) begin
                                drop_cnt_next = drop_cnt_reg + 32'd1;
                            end
                            m_item_next.drop_total = drop_cnt_next;
                        end else begin
                            len_we  = 1'b1;
                            ws_next = ws_wrap;
                        end
                        byte_off_next = '0;
                        ovl_next      = 1'b0;
                    end
                end else if (s_accept && ring_empty) begin
                    // Pop of an empty ring.
                    m_valid_next               = 1'b1;
                    m_item_next.result_status  = smrb_pkg::STAT_EMPTY;
                    m_item_next.out_byte       = 8'd0;
                    m_item_next.message_length = 7'd0;
                    m_item_next.final_flag     = 1'b1;
                    m_item_next.drop_total     = drop_cnt_reg;
                end else if (s_accept) begin
                    // Fetch the length and the first byte of the oldest slot.
                    len_re        = 1'b1;
                    st_re         = 1'b1;
                    st_raddr      = rs_base;
                    pop_addr_next = rs_base + ADDR_W'(1);
                    pop_idx_next  = '0;
                    rs_next       = rs_wrap;
                end
            end
            smrb_pkg::ST_POP: begin
                if (out_free) begin
                    m_valid_next               = 1'b1;
                    m_item_next.result_status  = smrb_pkg::STAT_OK;
                    m_item_next.drop_total     = drop_cnt_reg;
                    m_item_next.message_length = 7'(len_rdata_reg);
                    if (len_rdata_reg == '0) begin
                        // A message of zero bytes gives one empty result.
                        m_item_next.out_byte   = 8'd0;
                        m_item_next.final_flag = 1'b1;
                    end else begin
                        // Emit one byte and prefetch the next one.
                        m_item_next.out_byte   = st_rdata_reg;
                        m_item_next.final_flag = pop_last;
                        if (!pop_last) begin
                            st_re         = 1'b1;
                            pop_addr_next = pop_addr_reg + ADDR_W'(1);
                            pop_idx_next  = pop_idx_reg + OFF_W'(1);
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        // A register write initializes the ring.
        if (cfg_we) begin
            case (cfg_index)
                smrb_pkg::CFG_SLOT_COUNT: slot_count_next = cfg_data[4:0];
                smrb_pkg::CFG_ROOM_BYTES: room_bytes_next = cfg_data;
                default: begin
                end
            endcase
            ws_next       = '0;
            rs_next       = '0;
            byte_off_next = '0;
            ovl_next      = 1'b0;
            drop_cnt_next = '0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= smrb_pkg::ST_IDLE;
            slot_count_reg <= smrb_pkg::SLOT_COUNT_RST;
            room_bytes_reg <= smrb_pkg::ROOM_BYTES_RST;
            ws_reg         <= '0;
            rs_reg         <= '0;
            byte_off_reg   <= '0;
            ovl_reg        <= 1'b0;
            drop_cnt_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            slot_count_reg <= slot_count_next;
            room_bytes_reg <= room_bytes_next;
            ws_reg         <= ws_next;
            rs_reg         <= rs_next;
            byte_off_reg   <= byte_off_next;
            ovl_reg        <= ovl_next;
            drop_cnt_reg   <= drop_cnt_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        pop_idx_reg  <= pop_idx_next;
        pop_addr_reg <= pop_addr_next;
        m_item_reg   <= m_item_next;
    end

    // Byte memory of the slots.
    always_ff @(posedge aclk) begin
        if (st_we) begin
            store_mem[st_waddr] <= s_item.data_byte;
        end
        if (st_re) begin
            st_rdata_reg <= store_mem[st_raddr];
        end
    end

    // Length memory of the slots.
    always_ff @(posedge aclk) begin
        if (len_we) begin
            len_mem[ws_reg] <= len_wdata;
        end
        if (len_re) begin
            len_rdata_reg <= len_mem[rs_reg];
        end
    end

    // No item is taken while a message is being read out.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == smrb_pkg::ST_POP) |-> !s_ready)
        else $error("input taken during pop read-out");

    // Both slot pointers stay inside the configured ring.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (CNT_W'(ws_reg) < eff_slots) && (CNT_W'(rs_reg) < eff_slots))
        else $error("slot pointer outside ring");

    // The fill offset never passes the room of a slot.
    assert property (@(posedge aclk) disable iff (!aresetn)
        byte_off_reg <= eff_room)
        else $error("byte offset beyond slot room");

    // The read-out index stays below the message length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == smrb_pkg::ST_POP && len_rdata_reg != '0)
            |-> (pop_idx_reg < len_rdata_reg))
        else $error("read-out past message end");

    // The drop counter only falls on a register write.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !cfg_we |=> (drop_cnt_reg >= $past(drop_cnt_reg)))
        else $error("drop counter decreased");

endmodule

// ===== bench/smrb_ring_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Slotted message ring buffer result checker
// Watches the item, result and configuration ports of the ring buffer. It
// keeps its own copy of the ring, works out the results of every accepted
// input item and compares each accepted result, field by field, with the
// oldest result still awaited.
// ---------------------------------------------------------------------------
module smrb_ring_checker #(
    parameter int unsigned SLOTS    = smrb_pkg::SLOTS_DEF,
    parameter int unsigned MAX_ROOM = smrb_pkg::MAX_ROOM_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  smrb_pkg::in_item_t              s_item,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  smrb_pkg::out_item_t             m_item,
    input  logic                            cfg_we,
    input  logic [smrb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [smrb_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              fail_count,
    output int                              pending
);

    // Results worked out but not yet seen on the result channel.
    smrb_pkg::out_item_t awaited_results[$];

    // Shadow copy of the ring and its registers.
    logic [7:0]  slot_bytes [SLOTS*MAX_ROOM];
    int unsigned slot_len [SLOTS];
    int unsigned wr_slot;
    int unsigned rd_slot;
    int unsigned fill;
    bit          too_long;
    logic [31:0] drops;
    logic [4:0]  slot_reg;
    logic [6:0]  room_reg;
    int          fails = 0;

    // Slot count and room size as the ring uses them, after clamping.
    function automatic int unsigned slots_used();
        if (slot_reg < 5'd2) return 2;
        if (32'(slot_reg) > SLOTS) return SLOTS;
        return 32'(slot_reg);
    endfunction

    function automatic int unsigned room_used();
        if (room_reg < 7'd1) return 1;
        if (32'(room_reg) > MAX_ROOM) return MAX_ROOM;
        return 32'(room_reg);
    endfunction

    function automatic int unsigned next_slot(int unsigned s);
        return (s + 1 >= slots_used()) ? 0 : s + 1;
    endfunction

    // A register write or a reset empties the ring and clears the drop count.
    task automatic restart_ring();
        wr_slot  = 0;
        rd_slot  = 0;
        fill     = 0;
        too_long = 1'b0;
        drops    = '0;
    endtask

    task automatic await_result(smrb_pkg::status_t st, logic [7:0] b, int unsigned len,
                                bit last);
        smrb_pkg::out_item_t r;
        r.result_status  = st;
        r.out_byte       = b;
        r.message_length = 7'(len);
        r.final_flag     = last;
        r.drop_total     = drops;
        awaited_results.push_back(r);
    endtask

    // Work out the results of one accepted input item and update the ring.
    task automatic predict_ring_results(smrb_pkg::in_item_t it);
        smrb_pkg::status_t st;
        int unsigned       len;
        int unsigned       base;
        if (it.action == smrb_pkg::ACT_PUSH) begin
            st = smrb_pkg::STAT_OK;
            // A final item with the empty flag carries no byte.
            if (!(it.end_of_message && it.empty_message)) begin
                if (fill < room_used()) begin
                    slot_bytes[wr_slot*MAX_ROOM + fill] = it.data_byte;
                    fill++;
                end else begin
                    too_long = 1'b1;
                    st = smrb_pkg::STAT_TOO_LONG;
                end
            end
            len = fill;
            // Commit the message, or drop it whole when the ring is full.
            if (it.end_of_message) begin
                if (too_long) st = smrb_pkg::STAT_TOO_LONG;
                if (next_slot(wr_slot) == rd_slot) begin
                    if (drops != 32'hFFFF_FFFF) drops++;
                    st = smrb_pkg::STAT_FULL;
                end else begin
                    slot_len[wr_slot] = fill;
                    wr_slot = next_slot(wr_slot);
                end
                fill = 0;
                too_long = 1'b0;
            end
            await_result(st, 8'h00, len, 1'b1);
        end else if (wr_slot == rd_slot) begin
            await_result(smrb_pkg::STAT_EMPTY, 8'h00, 0, 1'b1);
        end else begin
            base = rd_slot * MAX_ROOM;
            len = slot_len[rd_slot];
            rd_slot = next_slot(rd_slot);
            if (len == 0) begin
                await_result(smrb_pkg::STAT_OK, 8'h00, 0, 1'b1);
            end else begin
                for (int unsigned i = 0; i < len; i++) begin
                    await_result(smrb_pkg::STAT_OK, slot_bytes[base + i], len, i == len - 1);
                end
            end
        end
    endtask

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fails++;
        end
    endtask

    // Compare one accepted result item with the oldest awaited one.
    task automatic check_result(smrb_pkg::out_item_t got);
        smrb_pkg::out_item_t want;
        if (awaited_results.size() == 0) begin
            $display("%0t ns: result item with none awaited, expected nothing, actual %h",
                     $time, got);
            fails++;
        end else begin
            want = awaited_results.pop_front();
            compare_field("result_status", 32'(want.result_status), 32'(got.result_status));
            compare_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
            compare_field("message_length", 32'(want.message_length),
                          32'(got.message_length));
            compare_field("final_flag", 32'(want.final_flag), 32'(got.final_flag));
            compare_field("drop_total", want.drop_total, got.drop_total);
        end
    endtask

    // Sample all three ports at the rising edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            awaited_results.delete();
            slot_reg = smrb_pkg::SLOT_COUNT_RST;
            room_reg = smrb_pkg::ROOM_BYTES_RST;
            restart_ring();
        end else begin
            if (cfg_we) begin
                if (cfg_index == smrb_pkg::CFG_SLOT_COUNT) begin
                    slot_reg = cfg_data[4:0];
                end else if (cfg_index == smrb_pkg::CFG_ROOM_BYTES) begin
                    room_reg = cfg_data[6:0];
                end
                restart_ring();
            end
            if (s_valid && s_ready) predict_ring_results(s_item);
            if (m_valid && m_ready) check_result(m_item);
        end
        pending = awaited_results.size();
        fail_count = fails;
    end

endmodule

// ===== bench/tb_slotted_message_ring_buffer.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Slotted message ring buffer testbench
// Drives message pushes and pops into the ring buffer through several
// register settings, with bursty input, a receiver that stalls on a pattern
// of its own and one long output hold-off. A separate checker predicts and
// compares every result item; this top gives the verdict.
// ---------------------------------------------------------------------------
module tb_slotted_message_ring_buffer;

    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int END_WAIT    = 80;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 25;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    smrb_pkg::in_item_t              s_item;
    logic                            m_valid;
    logic                            m_ready;
    smrb_pkg::out_item_t             m_item;
    logic                            cfg_we;
    logic [smrb_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [smrb_pkg::CFG_DATA_W-1:0] cfg_data;

    int          fail_count;
    int          pending;
    int          items_sent = 0;
    int          burst_left = 0;
    int          idle_cycles = 0;
    bit          hold_output = 1'b0;
    int unsigned slots_now = smrb_pkg::SLOTS_DEF;
    int unsigned room_now = smrb_pkg::MAX_ROOM_DEF;

    // Register settings of the random phases: low ends, out of range and
    // masked values, and the top ends.
    int slot_plan [PHASES] = '{2, 0, 127, 5, 17, 3, 16};
    int room_plan [PHASES] = '{1, 0, 127, 7, 65, 2, 64};

    slotted_message_ring_buffer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    smrb_ring_checker u_ring_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fail_count(fail_count),
        .pending   (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Offer one item in the current burst, or after a random gap, and wait
    // until it is accepted.
    task automatic send_item(smrb_pkg::in_item_t it);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 10);
            burst_left = $urandom_range(1, 40);
        end else begin
            burst_left--;
        end
        if (gap > 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid = 1'b1;
        s_item = it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic push_byte(logic [7:0] b, logic eom, logic empty);
        smrb_pkg::in_item_t it;
        it.action = smrb_pkg::ACT_PUSH;
        it.data_byte = b;
        it.end_of_message = eom;
        it.empty_message = empty;
        send_item(it);
    endtask

    // Pop with random contents in the fields that a pop does not use.
    task automatic pop_message();
        smrb_pkg::in_item_t it;
        it.action = smrb_pkg::ACT_POP;
        it.data_byte = 8'($urandom);
        it.end_of_message = 1'($urandom);
        it.empty_message = 1'($urandom);
        send_item(it);
    endtask

    // A well-formed message of len bytes. With tail_empty, or with no bytes,
    // it ends on an item with both flags set that stores nothing.
    task automatic push_message(int unsigned len, bit tail_empty);
        logic eom;
        for (int unsigned i = 0; i < len; i++) begin
            eom = (i == len - 1) && !tail_empty;
            push_byte(8'($urandom), eom, eom ? 1'b0 : 1'($urandom));
        end
        if (len == 0 || tail_empty) push_byte(8'($urandom), 1'b1, 1'b1);
    endtask

    // Mostly short messages, now and then one around the room size.
    function automatic int unsigned pick_length();
        int unsigned short_max;
        if ($urandom_range(0, 11) == 0) return $urandom_range(room_now - 1, room_now + 2);
        short_max = (room_now + 1 < 5) ? room_now + 1 : 5;
        return $urandom_range(0, short_max);
    endfunction

    // Stop offering items until every awaited result has come.
    task automatic drain_results();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(logic [smrb_pkg::CFG_IDX_W-1:0] idx,
                             logic [smrb_pkg::CFG_DATA_W-1:0] val);
        drain_results();
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge aclk);
        cfg_we = 1'b0;
        if (idx == smrb_pkg::CFG_SLOT_COUNT) begin
            slots_now = (val[4:0] < 5'd2) ? 2 :
                        (32'(val[4:0]) > smrb_pkg::SLOTS_DEF) ? smrb_pkg::SLOTS_DEF :
                        32'(val[4:0]);
        end else begin
            room_now = (val < 7'd1) ? 1 :
                       (32'(val) > smrb_pkg::MAX_ROOM_DEF) ? smrb_pkg::MAX_ROOM_DEF :
                       32'(val);
        end
    endtask

    // Random mix of messages, pops, ring fills and loose items.
    task automatic run_phase(int n_items);
        int stop_at;
        int pick;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                push_message(pick_length(), $urandom_range(0, 5) == 0);
            end else if (pick < 85) begin
                pop_message();
            end else if (pick < 92) begin
                // Push one message more than the ring holds.
                for (int unsigned k = 0; k < slots_now; k++) begin
                    push_message($urandom_range(0, 2), 1'b0);
                end
            end else begin
                push_byte(8'($urandom), 1'($urandom), 1'($urandom));
            end
        end
    endtask

    // Receiver: ready pattern changes from span to span, with one long
    // hold-off on request.
    initial begin : rx_pattern
        int mode;
        int span;
        m_ready = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 120);
            repeat (span) begin
                @(negedge aclk);
                if (hold_output) begin
                    m_ready = 1'b0;
                    repeat (HOLD_CYCLES) @(negedge aclk);
                    hold_output = 1'b0;
                end
                case (mode)
                    0: m_ready = 1'b1;
                    1: m_ready = 1'($urandom);
                    2: m_ready = ($urandom_range(0, 3) == 0);
                    default: m_ready = ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Watchdog: ends the run when no port has moved for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("[slotted_message_ring_buffer] ERROR");
                $finish;
            end
        end
    end

    // Main stimulus.
    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item = '0;
        cfg_we = 1'b0;
        cfg_index = smrb_pkg::CFG_SLOT_COUNT;
        cfg_data = '0;
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        // Default sizes: empty pop, byte extremes, a zero-length message,
        // a loose empty flag and a message closed by an empty final item.
        pop_message();
        push_byte(8'hFF, 1'b1, 1'b0);
        push_byte(8'h00, 1'b1, 1'b0);
        push_byte(8'h5C, 1'b1, 1'b1);
        push_byte(8'hA5, 1'b0, 1'b1);
        push_byte(8'h5A, 1'b0, 1'b0);
        push_byte(8'h33, 1'b1, 1'b1);
        repeat (5) pop_message();

        // Smallest ring and room: overlong message, full ring, and a message
        // that is both overlong and dropped.
        write_reg(smrb_pkg::CFG_SLOT_COUNT, 7'd2);
        write_reg(smrb_pkg::CFG_ROOM_BYTES, 7'd1);
        push_byte(8'h11, 1'b0, 1'b0);
        push_byte(8'h22, 1'b0, 1'b0);
        push_byte(8'h33, 1'b1, 1'b0);
        push_byte(8'h44, 1'b1, 1'b0);
        push_byte(8'h55, 1'b0, 1'b0);
        push_byte(8'h66, 1'b1, 1'b0);
        pop_message();
        pop_message();

        // Random phases, one per register setting.
        for (int p = 0; p < PHASES; p++) begin
            write_reg(smrb_pkg::CFG_SLOT_COUNT, 7'(slot_plan[p]));
            write_reg(smrb_pkg::CFG_ROOM_BYTES, 7'(room_plan[p]));
            if (p == 3) hold_output = 1'b1;
            run_phase(PHASE_ITEMS);
        end

        drain_results();
        repeat (END_WAIT) @(negedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("[slotted_message_ring_buffer] OK");
        end else begin
            $display("[slotted_message_ring_buffer] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/smrb_pkg.sv
design/slotted_message_ring_buffer.sv
bench/smrb_ring_checker.sv
bench/tb_slotted_message_ring_buffer.sv
